// File: src/interval_multiply_double_top_macros.svh
// ----------------------------------------------------------------------------
// interval multiply assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef INTERVAL_MULTIPLY_DOUBLE_TOP_MACROS_SVH
`define INTERVAL_MULTIPLY_DOUBLE_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define IMD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define IMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/imd_pkg.sv
// ----------------------------------------------------------------------------
// imd_pkg
// shared types, constants and bound-selection codes for interval multiply
// ----------------------------------------------------------------------------
package imd_pkg;

    localparam int unsigned PipeDepth = 6;

    localparam logic [63:0] DefNan    = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] MaxFinite = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ExpAll    = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [63:0] a_lo;
        logic [63:0] a_hi;
        logic [63:0] b_lo;
        logic [63:0] b_hi;
    } imd_in_t;

    typedef struct packed {
        logic [63:0] prod_lo;
        logic [63:0] prod_hi;
    } imd_out_t;

    // operand selection for one bound product
    typedef enum logic [1:0] {
        SEL_LO_LO = 2'd0,
        SEL_LO_HI = 2'd1,
        SEL_HI_LO = 2'd2,
        SEL_HI_HI = 2'd3
    } sel_t;

    // how the final bound is formed
    typedef enum logic [1:0] {
        FORM_ZERO   = 2'd0,
        FORM_SINGLE = 2'd1,
        FORM_MINMAX = 2'd2
    } form_t;

    // decoded special-case info carried beside a product
    typedef struct packed {
        logic        special;
        logic [63:0] special_val;
        logic        sgn;
        logic        away;
    } mul_ctl_t;

    function automatic logic is_nan(input logic [63:0] x);
        return x[62:0] > ExpAll[62:0];
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

    function automatic logic less_than(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] kx;
        logic [63:0] ky;
        kx = x[63] ? ~x : (x | 64'h8000_0000_0000_0000);
        ky = y[63] ? ~y : (y | 64'h8000_0000_0000_0000);
        if (is_nan(x) || is_nan(y))
            return 1'b0;
        if (is_zero(x) && is_zero(y))
            return 1'b0;
        return kx < ky;
    endfunction

endpackage

// File: src/imd_fmul.sv
// ----------------------------------------------------------------------------
// imd_fmul
// pipelined double multiply with directed rounding, five register stages
// ----------------------------------------------------------------------------
module imd_fmul
    import imd_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] x,
    input  logic [63:0] y,
    input  logic        toward_pos,
    output logic [63:0] res
);

    // stage 1: unpack, special cases, partial products
    mul_ctl_t    c1_reg;
    logic signed [13:0] e1_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;

    // stage 2: product assembly
    mul_ctl_t    c2_reg;
    logic signed [13:0] e2_reg;
    logic [127:0] prod2_reg;

    // stage 3: leading-one position
    mul_ctl_t    c3_reg;
    logic signed [13:0] e3_reg;
    logic [127:0] prod3_reg;
    logic [7:0]  len3_reg;

    // stage 4: aligned significand and sticky
    mul_ctl_t    c4_reg;
    logic signed [13:0] k4_reg;
    logic [63:0] q4_reg;
    logic        st4_reg;

    mul_ctl_t    c1_next;
    logic signed [13:0] e1_next;
    logic [52:0] mx, my;
    logic [10:0] ex, ey;
    logic        sgn;

    always_comb
    begin
        ex = x[62:52];
        ey = y[62:52];
        sgn = x[63] ^ y[63];
        mx = {ex != 11'd0, x[51:0]};
        my = {ey != 11'd0, y[51:0]};
        e1_next = ((ex != 11'd0) ? ($signed({3'd0, ex}) - 14'sd1075) : -14'sd1074)
                + ((ey != 11'd0) ? ($signed({3'd0, ey}) - 14'sd1075) : -14'sd1074);
        c1_next.sgn = sgn;
        c1_next.away = toward_pos ? !sgn : sgn;
        c1_next.special = 1'b1;
        c1_next.special_val = 64'd0;
        if (is_nan(x))
            c1_next.special_val = x | 64'h0008_0000_0000_0000;
        else if (is_nan(y))
            c1_next.special_val = y | 64'h0008_0000_0000_0000;
        else if (ex == 11'h7FF || ey == 11'h7FF)
            c1_next.special_val = (is_zero(x) || is_zero(y)) ? DefNan : {sgn, ExpAll[62:0]};
        else if (is_zero(x) || is_zero(y))
            c1_next.special_val = {sgn, 63'd0};
        else
            c1_next.special = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg  <= c1_next;
            e1_reg  <= e1_next;
            p00_reg <= {32'd0, mx[31:0]} * {32'd0, my[31:0]};
            p01_reg <= 64'({32'd0, mx[31:0]} * {43'd0, my[52:32]});
            p10_reg <= 64'({43'd0, mx[52:32]} * {32'd0, my[31:0]});
            p11_reg <= 64'({43'd0, mx[52:32]} * {43'd0, my[52:32]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg <= c1_reg;
            e2_reg <= e1_reg;
            prod2_reg <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                       + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
        end
    end

    // leading-one search over the product
    logic [7:0] len_next;
    always_comb
    begin
        len_next = 8'd0;
        for (int i = 0; i < 128; i++)
            if (prod2_reg[i])
                len_next = 8'(i + 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg <= c2_reg;
            e3_reg <= e2_reg;
            prod3_reg <= prod2_reg;
            len3_reg <= len_next;
        end
    end

    logic signed [14:0] s_val;
    logic [255:0]       wide;
    logic [127:0]       mask;
    logic [63:0]        q_next;
    logic               st_next;
    logic [7:0]         sh;
    always_comb
    begin
        s_val = $signed({7'd0, len3_reg}) - 15'sd53;
        if (15'(e3_reg) + s_val < -15'sd1074)
            s_val = -15'sd1074 - 15'(e3_reg);
        q_next = 64'd0;
        st_next = 1'b0;
        sh = 8'd0;
        wide = 256'd0;
        mask = 128'd0;
        if (s_val <= 15'sd0)
        begin
            q_next = prod3_reg[63:0] << 6'(-s_val);
        end
        else if (s_val < 15'sd128)
        begin
            sh = 8'(s_val);
            wide = {prod3_reg, 128'd0} >> sh;
            q_next = wide[191:128];
            mask = (128'd1 << sh) - 128'd1;
            st_next = |(prod3_reg & mask);
        end
        else
        begin
            st_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c4_reg <= c3_reg;
            k4_reg <= 14'(15'(e3_reg) + s_val);
            q4_reg <= q_next;
            st4_reg <= st_next;
        end
    end

    logic [63:0]        q_r;
    logic signed [13:0] k_r;
    logic [63:0]        res_next;
    always_comb
    begin
        q_r = q4_reg;
        k_r = k4_reg;
        if (st4_reg && c4_reg.away)
        begin
            q_r = q4_reg + 64'd1;
            if (q_r == 64'h0020_0000_0000_0000)
            begin
                q_r = 64'h0010_0000_0000_0000;
                k_r = k4_reg + 14'sd1;
            end
        end
        if (c4_reg.special)
            res_next = c4_reg.special_val;
        else if (k_r > 14'sd971)
            res_next = {c4_reg.sgn, c4_reg.away ? ExpAll[62:0] : MaxFinite[62:0]};
        else
            res_next = {c4_reg.sgn, 63'd0}
                     | (({50'd0, 14'(k_r + 14'sd1074)} << 52) + q_r);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res <= res_next;
    end

endmodule

// File: src/imd_classify.sv
// ----------------------------------------------------------------------------
// imd_classify
// classifies the sign of both operand intervals and picks operands for the bound products
// ----------------------------------------------------------------------------
module imd_classify
    import imd_pkg::*;
(
    input  imd_in_t     din,
    output logic [63:0] l1_x, l1_y, l2_x, l2_y,
    output logic [63:0] h1_x, h1_y, h2_x, h2_y,
    output form_t       form
);

    logic an, ap, bn, bp;
    sel_t l1, l2, h1, h2;

    function automatic logic [127:0] pick(input sel_t s, input imd_in_t d);
        case (s)
            SEL_LO_LO: return {d.a_lo, d.b_lo};
            SEL_LO_HI: return {d.a_lo, d.b_hi};
            SEL_HI_LO: return {d.a_hi, d.b_lo};
            SEL_HI_HI: return {d.a_hi, d.b_hi};
            default:   return {d.a_lo, d.b_lo};
        endcase
    endfunction

    always_comb
    begin
        an = din.a_lo[63] && !is_nan(din.a_lo) && !is_zero(din.a_lo);
        ap = !din.a_hi[63] && !is_nan(din.a_hi) && !is_zero(din.a_hi);
        bn = din.b_lo[63] && !is_nan(din.b_lo) && !is_zero(din.b_lo);
        bp = !din.b_hi[63] && !is_nan(din.b_hi) && !is_zero(din.b_hi);
        form = FORM_SINGLE;
        l1 = SEL_LO_LO; h1 = SEL_LO_LO; l2 = SEL_HI_LO; h2 = SEL_HI_HI;
        if (an && ap)
        begin
            if (bn && bp)
            begin
                form = FORM_MINMAX;
                l1 = SEL_LO_HI; l2 = SEL_HI_LO; h1 = SEL_LO_LO; h2 = SEL_HI_HI;
            end
            else if (bn) begin l1 = SEL_HI_LO; h1 = SEL_LO_LO; end
            else if (bp) begin l1 = SEL_LO_HI; h1 = SEL_HI_HI; end
            else form = FORM_ZERO;
        end
        else if (an)
        begin
            if (bn && bp) begin l1 = SEL_LO_HI; h1 = SEL_LO_LO; end
            else if (bn) begin l1 = SEL_HI_HI; h1 = SEL_LO_LO; end
            else if (bp) begin l1 = SEL_LO_HI; h1 = SEL_HI_LO; end
            else form = FORM_ZERO;
        end
        else if (ap)
        begin
            if (bn && bp) begin l1 = SEL_HI_LO; h1 = SEL_HI_HI; end
            else if (bn) begin l1 = SEL_HI_LO; h1 = SEL_LO_HI; end
            else if (bp) begin l1 = SEL_LO_LO; h1 = SEL_HI_HI; end
            else form = FORM_ZERO;
        end
        else
            form = FORM_ZERO;
        {l1_x, l1_y} = pick(l1, din);
        {l2_x, l2_y} = pick(l2, din);
        {h1_x, h1_y} = pick(h1, din);
        {h2_x, h2_y} = pick(h2, din);
    end

endmodule

// File: src/interval_multiply_double_top.sv
// ----------------------------------------------------------------------------
// interval_multiply_double_top
// interval product of two double-precision intervals with outward rounding
// ----------------------------------------------------------------------------
// Takes one word of two intervals [a_lo,a_hi] and [b_lo,b_hi] per cycle and
// returns [prod_lo,prod_hi], lower bound rounded toward minus infinity and
// upper bound toward plus infinity. The pipeline is one classify
// register, five stages in each of four parallel multipliers, and one
// min/max output register. A new word is taken every cycle unless the
// input is stalled; the whole pipeline advances together, so a stall on
// the output freezes every stage, and the input is stalled only while the
// output register holds a word that is itself stalled.
module interval_multiply_double_top
    import imd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  imd_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output imd_out_t out_data
);

    // pipeline advances when the output slot is free or being taken
    logic adv;
    assign adv = !out_valid || !out_stall;
    assign in_stall = !adv;

    // classify and operand select
    logic [63:0] l1_x, l1_y, l2_x, l2_y, h1_x, h1_y, h2_x, h2_y;
    form_t       form_c;
    imd_classify u_cls (
        .din  (in_data),
        .l1_x (l1_x), .l1_y (l1_y), .l2_x (l2_x), .l2_y (l2_y),
        .h1_x (h1_x), .h1_y (h1_y), .h2_x (h2_x), .h2_y (h2_y),
        .form (form_c)
    );

    logic [63:0] l1x_reg, l1y_reg, l2x_reg, l2y_reg;
    logic [63:0] h1x_reg, h1y_reg, h2x_reg, h2y_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1x_reg <= l1_x; l1y_reg <= l1_y; l2x_reg <= l2_x; l2y_reg <= l2_y;
            h1x_reg <= h1_x; h1y_reg <= h1_y; h2x_reg <= h2_x; h2y_reg <= h2_y;
        end
    end

    // valid and form travel with the data
    logic  [PipeDepth-1:0] vld_reg;
    form_t                 form_reg [PipeDepth];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PipeDepth-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            form_reg[0] <= form_c;
            for (int i = 1; i < PipeDepth; i++)
                form_reg[i] <= form_reg[i-1];
        end
    end

    logic [63:0] rl1, rl2, rh1, rh2;
    imd_fmul u_l1 (.clk(clk), .en(adv), .x(l1x_reg), .y(l1y_reg),
                   .toward_pos(1'b0), .res(rl1));
    imd_fmul u_l2 (.clk(clk), .en(adv), .x(l2x_reg), .y(l2y_reg),
                   .toward_pos(1'b0), .res(rl2));
    imd_fmul u_h1 (.clk(clk), .en(adv), .x(h1x_reg), .y(h1y_reg),
                   .toward_pos(1'b1), .res(rh1));
    imd_fmul u_h2 (.clk(clk), .en(adv), .x(h2x_reg), .y(h2y_reg),
                   .toward_pos(1'b1), .res(rh2));

    // final min/max or zero and output register
    imd_out_t out_next;
    always_comb
    begin
        case (form_reg[PipeDepth-1])
            FORM_ZERO:
            begin
                out_next.prod_lo = 64'd0;
                out_next.prod_hi = 64'd0;
            end
            FORM_MINMAX:
            begin
                out_next.prod_lo = less_than(rl2, rl1) ? rl2 : rl1;
                out_next.prod_hi = less_than(rh1, rh2) ? rh2 : rh1;
            end
            default:
            begin
                out_next.prod_lo = rl1;
                out_next.prod_hi = rh1;
            end
        endcase
    end

    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[PipeDepth-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data <= out_next;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/imd_checker.sv
// ----------------------------------------------------------------------------
// imd_checker
// port-level checks for the interval multiply pipeline
// ----------------------------------------------------------------------------
`include "interval_multiply_double_top_macros.svh"

module imd_checker
    import imd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input imd_out_t out_data
);

    `IMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled output word changed")
    `IMD_ASSERT_IMPL(a_in_stall, clk, rst_n, in_stall,
        out_valid && out_stall, "input stalled while output free")
    `IMD_ASSERT_IMPL(a_no_stall, clk, rst_n, !out_valid,
        !in_stall, "input stalled with empty output")

endmodule

bind interval_multiply_double_top imd_checker u_imd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: dv/tb_interval_multiply_double_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interval_multiply_double_top
// self-checking bench for the double-precision interval multiplier
// ----------------------------------------------------------------------------
// A table of directed words runs first. A random run of about 1150 words
// follows, biased toward ordinary intervals of every sign class, with some
// raw bit-pattern noise. A local model of the directed-rounding multiplier
// predicts every result that the table does not give. Results are checked
// in order against a queue of expected bounds. The sender and the receiver
// idle at random in the first two of three phases, and at one point the sender waits until the queue has drained.
// ----------------------------------------------------------------------------
module tb_interval_multiply_double_top;
    import imd_pkg::*;

    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ABS_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] QUIET     = 64'h0008_0000_0000_0000;
    localparam logic [63:0] ONE       = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] TWO       = 64'h4000_0000_0000_0000;
    localparam logic [63:0] MIN_SUB   = 64'h0000_0000_0000_0001;
    localparam int          NUM_RAND  = 1150;
    localparam int          NUM_ROWS  = 22;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    imd_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    imd_out_t out_data;

    imd_out_t bound_q[$];
    int       err_cnt;
    int       send_idle_pct;
    int       recv_idle_pct;

    interval_multiply_double_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // free-running clock, period 2 ns
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic logic f_nan(input logic [63:0] x);
        return (x & ABS_MASK) > ExpAll;
    endfunction

    function automatic logic f_zero(input logic [63:0] x);
        return (x & ABS_MASK) == 64'd0;
    endfunction

    // strictly negative or strictly positive, nan counts as neither
    function automatic logic f_neg(input logic [63:0] x);
        return x[63] && !f_nan(x) && !f_zero(x);
    endfunction

    function automatic logic f_pos(input logic [63:0] x);
        return !x[63] && !f_nan(x) && !f_zero(x);
    endfunction

    function automatic logic f_lt(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] kx;
        logic [63:0] ky;
        kx = x[63] ? ~x : (x | SIGN_MASK);
        ky = y[63] ? ~y : (y | SIGN_MASK);
        if (f_nan(x) || f_nan(y))
            return 1'b0;
        if (f_zero(x) && f_zero(y))
            return 1'b0;
        return kx < ky;
    endfunction

    // product of two doubles, rounded toward +inf when up is set, else -inf
    function automatic logic [63:0] dir_mul(input logic [63:0] x, input logic [63:0] y,
                                            input logic up);
        logic [63:0]  sgn;
        logic [10:0]  ex;
        logic [10:0]  ey;
        logic [127:0] prod;
        logic [127:0] shifted;
        logic [127:0] rest;
        logic [63:0]  q;
        logic         away;
        logic         sticky;
        int           e;
        int           len;
        int           s;
        int           k;
        sgn  = (x ^ y) & SIGN_MASK;
        ex   = x[62:52];
        ey   = y[62:52];
        away = up ? (sgn == 64'd0) : (sgn != 64'd0);
        if (f_nan(x))
            return x | QUIET;
        if (f_nan(y))
            return y | QUIET;
        if (ex == 11'h7FF || ey == 11'h7FF)
        begin
            if (f_zero(x) || f_zero(y))
                return DefNan;
            return sgn | ExpAll;
        end
        if (f_zero(x) || f_zero(y))
            return sgn;
        prod = {75'd0, (ex != 11'd0), x[51:0]} * {75'd0, (ey != 11'd0), y[51:0]};
        e = ((ex != 0) ? int'(ex) - 1075 : -1074) + ((ey != 0) ? int'(ey) - 1075 : -1074);
        len = 0;
        for (int i = 0; i < 128; i++)
            if (prod[i])
                len = i + 1;
        s = len - 53;
        if (e + s < -1074)
            s = -1074 - e;
        k = e + s;
        if (s <= 0)
        begin
            q = prod[63:0] << (-s);
            sticky = 1'b0;
        end
        else if (s >= 128)
        begin
            q = 64'd0;
            sticky = 1'b1;
        end
        else
        begin
            shifted = prod >> s;
            rest    = prod & ((128'd1 << s) - 128'd1);
            q       = shifted[63:0];
            sticky  = (rest != 0);
        end
        if (sticky && away)
        begin
            q = q + 64'd1;
            if (q == 64'h0020_0000_0000_0000)
            begin
                q = 64'h0010_0000_0000_0000;
                k = k + 1;
            end
        end
        if (k > 971)
            return sgn | (away ? ExpAll : MaxFinite);
        return sgn | ((64'(k + 1074) << 52) + q);
    endfunction

    function automatic imd_out_t interval_product(input imd_in_t w);
        imd_out_t r;
        logic an;
        logic ap;
        logic bn;
        logic bp;
        an = f_neg(w.a_lo);
        ap = f_pos(w.a_hi);
        bn = f_neg(w.b_lo);
        bp = f_pos(w.b_hi);
        r  = '0;
        if (an && ap)
        begin
            if (bn && bp)
            begin
                r.prod_lo = dir_mul(w.a_lo, w.b_hi, 1'b0);
                if (f_lt(dir_mul(w.a_hi, w.b_lo, 1'b0), r.prod_lo))
                    r.prod_lo = dir_mul(w.a_hi, w.b_lo, 1'b0);
                r.prod_hi = dir_mul(w.a_lo, w.b_lo, 1'b1);
                if (f_lt(r.prod_hi, dir_mul(w.a_hi, w.b_hi, 1'b1)))
                    r.prod_hi = dir_mul(w.a_hi, w.b_hi, 1'b1);
            end
            else if (bn)
            begin
                r.prod_lo = dir_mul(w.a_hi, w.b_lo, 1'b0);
                r.prod_hi = dir_mul(w.a_lo, w.b_lo, 1'b1);
            end
            else if (bp)
            begin
                r.prod_lo = dir_mul(w.a_lo, w.b_hi, 1'b0);
                r.prod_hi = dir_mul(w.a_hi, w.b_hi, 1'b1);
            end
        end
        else if (an)
        begin
            if (bn && bp)
            begin
                r.prod_lo = dir_mul(w.a_lo, w.b_hi, 1'b0);
                r.prod_hi = dir_mul(w.a_lo, w.b_lo, 1'b1);
            end
            else if (bn)
            begin
                r.prod_lo = dir_mul(w.a_hi, w.b_hi, 1'b0);
                r.prod_hi = dir_mul(w.a_lo, w.b_lo, 1'b1);
            end
            else if (bp)
            begin
                r.prod_lo = dir_mul(w.a_lo, w.b_hi, 1'b0);
                r.prod_hi = dir_mul(w.a_hi, w.b_lo, 1'b1);
            end
        end
        else if (ap)
        begin
            if (bn && bp)
            begin
                r.prod_lo = dir_mul(w.a_hi, w.b_lo, 1'b0);
                r.prod_hi = dir_mul(w.a_hi, w.b_hi, 1'b1);
            end
            else if (bn)
            begin
                r.prod_lo = dir_mul(w.a_hi, w.b_lo, 1'b0);
                r.prod_hi = dir_mul(w.a_lo, w.b_hi, 1'b1);
            end
            else if (bp)
            begin
                r.prod_lo = dir_mul(w.a_lo, w.b_lo, 1'b0);
                r.prod_hi = dir_mul(w.a_hi, w.b_hi, 1'b1);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random operands
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand_bits();
        return {$urandom(), $urandom()};
    endfunction

    // mostly normal magnitudes near one, sometimes extreme exponents
    function automatic logic [63:0] rand_mag();
        logic [10:0] expo;
        case ($urandom_range(0, 9))
            0: expo = 11'($urandom_range(0, 3));
            1: expo = 11'($urandom_range(2040, 2047));
            2: expo = 11'($urandom_range(0, 2047));
            default: expo = 11'($urandom_range(1000, 1046));
        endcase
        return {1'b0, expo, $urandom(), 20'($urandom())};
    endfunction

    // bounds of a randomly chosen sign class, ordered but for one zero-lower-bound case
    task automatic rand_interval(output logic [63:0] lo, output logic [63:0] hi);
        logic [63:0] m0;
        logic [63:0] m1;
        m0 = rand_mag();
        m1 = rand_mag();
        case ($urandom_range(0, 4))
            0:
            begin
                lo = m0 | SIGN_MASK;
                hi = m1;
            end
            1:
            begin
                lo = (m0 > m1 ? m0 : m1) | SIGN_MASK;
                hi = (m0 > m1 ? m1 : m0) | SIGN_MASK;
            end
            2:
            begin
                lo = m0 > m1 ? m1 : m0;
                hi = m0 > m1 ? m0 : m1;
            end
            3:
            begin
                lo = $urandom_range(0, 1) ? SIGN_MASK : 64'd0;
                hi = $urandom_range(0, 1) ? m1 : m1 | SIGN_MASK;
            end
            default:
            begin
                lo = m0 | SIGN_MASK;
                hi = $urandom_range(0, 1) ? SIGN_MASK : 64'd0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // compare each accepted result word with the oldest expected one
    always @(posedge clk)
    begin
        imd_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bound_q.size() == 0)
                report_mismatch("unexpected word", out_data.prod_lo, 64'd0);
            else
            begin
                want = bound_q.pop_front();
                if (out_data.prod_lo !== want.prod_lo)
                    report_mismatch("prod_lo", out_data.prod_lo, want.prod_lo);
                if (out_data.prod_hi !== want.prod_hi)
                    report_mismatch("prod_hi", out_data.prod_hi, want.prod_hi);
            end
        end
    end

    // receiver stall, changes on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    // present one word, hold it until accepted, then record its expectation
    task automatic send_word(input imd_in_t w, input imd_out_t want, input logic typed);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bound_q.push_back(typed ? want : interval_product(w));
        @(negedge clk);
    endtask

    // directed table: words, and the result where it is plain by inspection
    imd_in_t  dir_in[NUM_ROWS];
    imd_out_t dir_out[NUM_ROWS];
    logic     dir_typed[NUM_ROWS];

    task automatic set_row(input int i, input logic [63:0] al, input logic [63:0] ah,
                           input logic [63:0] bl, input logic [63:0] bh,
                           input logic typed, input logic [63:0] pl, input logic [63:0] ph);
        dir_in[i]    = '{a_lo: al, a_hi: ah, b_lo: bl, b_hi: bh};
        dir_out[i]   = '{prod_lo: pl, prod_hi: ph};
        dir_typed[i] = typed;
    endtask

    initial
    begin
        imd_in_t w;
        logic [63:0] lo;
        logic [63:0] hi;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        err_cnt       = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // zero-class operands give +0
        set_row(0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0);
        set_row(1, SIGN_MASK, SIGN_MASK, ONE, TWO, 1'b1, 64'd0, 64'd0);
        // nan bounds fall out of every class
        set_row(2, DefNan, DefNan, ONE, TWO, 1'b1, 64'd0, 64'd0);
        // positive times positive
        set_row(3, ONE, TWO, ONE, TWO, 1'b1, ONE, 64'h4010_0000_0000_0000);
        // negative times negative
        set_row(4, TWO | SIGN_MASK, ONE | SIGN_MASK, TWO | SIGN_MASK, ONE | SIGN_MASK,
                1'b1, ONE, 64'h4010_0000_0000_0000);
        // both straddling
        set_row(5, ONE | SIGN_MASK, TWO, TWO | SIGN_MASK, ONE,
                1'b1, 64'h4010_0000_0000_0000 | SIGN_MASK, TWO);
        // overflow: +inf upward, largest finite downward
        set_row(6, MaxFinite, MaxFinite, MaxFinite, MaxFinite, 1'b1, MaxFinite, ExpAll);
        // underflow: smallest subnormal squared
        set_row(7, MIN_SUB, MIN_SUB, MIN_SUB, MIN_SUB, 1'b1, 64'd0, MIN_SUB);
        // infinities
        set_row(8, ONE, ExpAll, ONE, ExpAll, 1'b1, ONE, ExpAll);
        set_row(9, ExpAll | SIGN_MASK, ExpAll, ONE, TWO, 1'b1,
                ExpAll | SIGN_MASK, ExpAll);
        // infinite bounds in both straddling intervals
        set_row(10, ExpAll | SIGN_MASK, ExpAll, ExpAll | SIGN_MASK, ExpAll, 1'b0, 0, 0);
        // nan upper bound of a negative interval
        set_row(11, ONE | SIGN_MASK, DefNan | 64'd5, ONE, TWO, 1'b0, 0, 0);
        // signaling nan lower bound, not a factor of either product
        set_row(12, ONE | SIGN_MASK, ONE, 64'h7FF0_0000_0000_0001 | SIGN_MASK, ONE,
                1'b0, 0, 0);
        // signed zero bounds
        set_row(13, 64'd0, ONE, SIGN_MASK, TWO, 1'b0, 0, 0);
        set_row(14, ONE | SIGN_MASK, SIGN_MASK, SIGN_MASK, ONE, 1'b0, 0, 0);
        // mixed classes
        set_row(15, ONE | SIGN_MASK, TWO, ONE, TWO, 1'b0, 0, 0);
        set_row(16, ONE | SIGN_MASK, TWO, TWO | SIGN_MASK, ONE | SIGN_MASK, 1'b0, 0, 0);
        set_row(17, TWO | SIGN_MASK, ONE | SIGN_MASK, ONE, TWO, 1'b0, 0, 0);
        set_row(18, ONE, TWO, TWO | SIGN_MASK, ONE | SIGN_MASK, 1'b0, 0, 0);
        // inexact rounding of thirds, all ones
        set_row(19, 64'h3FD5_5555_5555_5555 | SIGN_MASK, 64'h3FD5_5555_5555_5555,
                64'h3FEF_FFFF_FFFF_FFFF | SIGN_MASK, 64'h3FEF_FFFF_FFFF_FFFF, 1'b0, 0, 0);
        set_row(20, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b0, 0, 0);
        // subnormal boundary operands times values up to just above one
        set_row(21, 64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
                64'h3CA0_0000_0000_0001, 64'h3FF0_0000_0000_0001, 1'b0, 0, 0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_word(dir_in[i], dir_out[i], dir_typed[i]);

        for (int n = 0; n < NUM_RAND; n++)
        begin
            // three idle phases
            if (n < NUM_RAND / 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 62;
            end
            else if (n < 2 * NUM_RAND / 3)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // sender holds off until the pipe has drained
            if (n == NUM_RAND / 2)
            begin
                in_valid <= 1'b0;
                while (bound_q.size() != 0)
                    @(negedge clk);
            end
            if ($urandom_range(0, 9) == 0)
                w = '{a_lo: rand_bits(), a_hi: rand_bits(),
                      b_lo: rand_bits(), b_hi: rand_bits()};
            else
            begin
                rand_interval(lo, hi);
                w.a_lo = lo;
                w.a_hi = hi;
                rand_interval(lo, hi);
                w.b_lo = lo;
                w.b_hi = hi;
            end
            send_word(w, '0, 1'b0);
        end
        in_valid <= 1'b0;
        recv_idle_pct = 0;

        while (bound_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (err_cnt == 0)
            $display("tb_interval_multiply_double_top passed");
        else
            $display("tb_interval_multiply_double_top failed");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("tb_interval_multiply_double_top failed");
        $finish;
    end

endmodule
